/* rtl/core/rhc_pkg.sv */
// Shared types, constants and constant-divisor helpers of the RGB/HLS colour converter.
// No dependencies; the front, queue, back and top level import this package.
package rhc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIV_Q_W         = 8;
    localparam int DIV_NUM_W       = 16;
    localparam int DIV_DEN_W       = 8;

    localparam logic [1:0] OP_TO_HLS = 2'd0;
    localparam logic [1:0] OP_TO_RGB = 2'd1;
    localparam logic [1:0] OP_LUMA   = 2'd2;

    localparam logic [7:0] HUE_BASE_RED   = 8'd0;
    localparam logic [7:0] HUE_BASE_GREEN = 8'd80;
    localparam logic [7:0] HUE_BASE_BLUE  = 8'd160;
    localparam logic [7:0] HUE_FULL       = 8'd240;
    localparam logic [7:0] LUM_MAX        = 8'd240;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    // Classified item, as held in the queue between front and back.
    typedef struct packed {
        logic [1:0]            op;
        logic                  grey;
        logic [8:0]            sum;
        logic [7:0]            hue_base;
        logic                  hue_neg;
        logic [DIV_NUM_W-1:0]  hue_num;
        logic [DIV_DEN_W-1:0]  hue_den;
        logic [DIV_NUM_W-1:0]  sat_num;
        logic [DIV_DEN_W-1:0]  sat_den;
        logic [7:0]            in_hue;
        logic [7:0]            in_lum;
        logic [7:0]            in_sat;
        logic signed [10:0]    step;
        logic                  rel;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // x / 255 for x below 2^17: reciprocal estimate, then one correction.
    function automatic logic [9:0] f_udiv255(input logic [16:0] x);
        logic [25:0] p;
        logic [9:0]  q;
        logic [17:0] r;
        p = {9'd0, x} + {1'b0, x, 8'd0};
        q = p[25:16];
        r = {1'b0, x} - 18'(({8'd0, q} << 8) - {8'd0, q});
        if (r >= 18'd255) begin
            q = q + 10'd1;
        end
        return q;
    endfunction

    // x / 25 for x below 2^13.
    function automatic logic [8:0] f_udiv25(input logic [12:0] x);
        logic [24:0] p;
        logic [8:0]  q;
        logic [13:0] r;
        p = 25'(x) * 25'd2621;
        q = p[24:16];
        r = {1'b0, x} - ({5'd0, q} * 14'd25);
        if (r >= 14'd25) begin
            q = q + 9'd1;
        end
        return q;
    endfunction

    // x / 40 for x below 2^16.
    function automatic logic [10:0] f_udiv40(input logic [15:0] x);
        logic [26:0] p;
        logic [10:0] q;
        logic [16:0] r;
        p = 27'(x) * 27'd1638;
        q = p[26:16];
        r = {1'b0, x} - ({6'd0, q} * 17'd40);
        if (r >= 17'd40) begin
            q = q + 11'd1;
        end
        return q;
    endfunction

endpackage

/* rtl/core/rhc_if.sv */
// Valid/ready channel interfaces of the colour converter: input items and result items.
// Self-contained; used by the front, back and top level.
interface rhc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [23:0]        in_rgb;
    logic [7:0]         in_hue;
    logic [7:0]         in_lum;
    logic [7:0]         in_sat;
    logic signed [10:0] luma_step;
    logic               relative;

    modport source (output valid, op, in_rgb, in_hue, in_lum, in_sat, luma_step, relative,
                    input ready);
    modport sink   (input valid, op, in_rgb, in_hue, in_lum, in_sat, luma_step, relative,
                    output ready);
endinterface

interface rhc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] out_rgb;
    logic [7:0]  out_hue;
    logic [7:0]  out_lum;
    logic [7:0]  out_sat;

    modport source (output valid, out_rgb, out_hue, out_lum, out_sat, input ready);
    modport sink   (input valid, out_rgb, out_hue, out_lum, out_sat, output ready);
endinterface

/* rtl/core/rhc_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the quotient must fit in Q_W bits.
module rhc_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [CW-1:0]    r_rem [Q_W-1];
    logic [DEN_W-1:0] r_den [Q_W-1];
    logic [Q_W-1:0]   r_quo [Q_W];

    logic [CW-1:0]    rem_in [Q_W];
    logic [DEN_W-1:0] den_in [Q_W];
    logic [Q_W-1:0]   quo_in [Q_W];
    logic [CW-1:0]    trial  [Q_W];
    logic             fit    [Q_W];

    // Each stage tries the divisor shifted to its quotient bit.
    always_comb begin
        rem_in[0] = CW'(i_num);
        den_in[0] = i_den;
        quo_in[0] = '0;
        for (int k = 1; k < Q_W; k++) begin
            rem_in[k] = r_rem[k-1];
            den_in[k] = r_den[k-1];
            quo_in[k] = r_quo[k-1];
        end
        for (int k = 0; k < Q_W; k++) begin
            trial[k] = CW'(den_in[k]) << (Q_W - 1 - k);
            fit[k]   = (rem_in[k] >= trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_quo[k] <= quo_in[k] | (fit[k] ? (Q_W'(1) << (Q_W - 1 - k)) : '0);
            end
            for (int k = 0; k < Q_W - 1; k++) begin
                r_rem[k] <= fit[k] ? (rem_in[k] - trial[k]) : rem_in[k];
                r_den[k] <= den_in[k];
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

/* rtl/core/rhc_front.sv */
// Front of the colour converter: accept an item, find max/min and set up both divisions.
// Depends on rhc_pkg and rhc_in_if.
module rhc_front import rhc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    rhc_in_if.sink  i_in,
    input  logic    i_full,
    output logic    o_push,
    output t_work   o_work
);
    logic        r_valid;
    t_work       r_work;
    t_work       n_work;
    logic [7:0]  cr, cg, cb, mx, mn, d, dmag;
    logic [8:0]  sum, sat_den;

    assign o_push     = r_valid && !i_full;
    assign i_in.ready = !r_valid || !i_full;
    assign o_work     = r_work;

    always_comb begin
        cr = i_in.in_rgb[7:0];
        cg = i_in.in_rgb[15:8];
        cb = i_in.in_rgb[23:16];
        mx = cr;
        mn = cr;
        if (cg > mx) mx = cg;
        if (cb > mx) mx = cb;
        if (cg < mn) mn = cg;
        if (cb < mn) mn = cb;
        sum = {1'b0, mx} + {1'b0, mn};
        d   = mx - mn;

        n_work.op       = i_in.op;
        n_work.grey     = (d == 8'd0);
        n_work.sum      = sum;
        n_work.in_hue   = i_in.in_hue;
        n_work.in_lum   = i_in.in_lum;
        n_work.in_sat   = i_in.in_sat;
        n_work.step     = i_in.luma_step;
        n_work.rel      = i_in.relative;

        // Hue sector by dominant channel; keep the difference as sign and magnitude.
        if (mx == cr) begin
            n_work.hue_base = HUE_BASE_RED;
            n_work.hue_neg  = (cg < cb);
            dmag            = (cg < cb) ? (cb - cg) : (cg - cb);
        end else if (mx == cg) begin
            n_work.hue_base = HUE_BASE_GREEN;
            n_work.hue_neg  = (cb < cr);
            dmag            = (cb < cr) ? (cr - cb) : (cb - cr);
        end else begin
            n_work.hue_base = HUE_BASE_BLUE;
            n_work.hue_neg  = (cr < cg);
            dmag            = (cr < cg) ? (cg - cr) : (cr - cg);
        end

        sat_den = (sum <= 9'd255) ? sum : (9'd510 - sum);

        n_work.hue_num = DIV_NUM_W'(dmag) * DIV_NUM_W'(40);
        n_work.sat_num = DIV_NUM_W'(d) * DIV_NUM_W'(240);
        // A grey colour never uses the quotients; keep the divisors non-zero.
        n_work.hue_den = n_work.grey ? DIV_DEN_W'(1) : DIV_DEN_W'(d);
        n_work.sat_den = n_work.grey ? DIV_DEN_W'(1) : DIV_DEN_W'(sat_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_work <= n_work;
        end
    end

endmodule

/* rtl/core/rhc_queue.sv */
// Short FIFO of classified items between the front and the back.
// Depends on rhc_pkg.
module rhc_queue import rhc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_work     i_work,
    input  logic      i_pop,
    output t_work     o_work,
    output t_q_status o_status
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_work         r_mem [DEPTH];
    logic [IW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + IW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + IW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    assign o_work         = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

/* rtl/core/rhc_back.sv */
// Back of the colour converter: divisions, HLS assembly, luma step and HLS to RGB.
// Depends on rhc_pkg, rhc_div and rhc_out_if; all stages advance together.
module rhc_back import rhc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_work     i_work,
    output logic      o_take,
    rhc_out_if.source o_out
);
    typedef struct packed {
        logic [1:0]         op;
        logic               grey;
        logic [8:0]         sum;
        logic [7:0]         hue_base;
        logic               hue_neg;
        logic [7:0]         in_hue;
        logic [7:0]         in_lum;
        logic [7:0]         in_sat;
        logic signed [10:0] step;
        logic               rel;
    } t_side;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] h;
        logic [7:0] l;
        logic [7:0] s;
    } t_tail;

    typedef struct packed {
        t_tail      tl;
        logic [7:0] th;
        logic [7:0] tlum;
        logic [7:0] ts;
    } t_st1;

    typedef struct packed {
        t_tail      tl;
        logic [8:0] l255;
        logic [8:0] s255;
        logic [2:0] sector;
        logic [5:0] rem;
        logic       grey;
        logic [7:0] greyv;
    } t_st2;

    typedef struct packed {
        t_tail              tl;
        logic [8:0]         l255;
        logic               lowb;
        logic signed [18:0] pa;
        logic signed [18:0] pb;
        logic [2:0]         sector;
        logic [5:0]         rem;
        logic               grey;
        logic [7:0]         greyv;
    } t_st3;

    typedef struct packed {
        t_tail              tl;
        logic signed [10:0] maxc;
        logic signed [10:0] minc;
        logic signed [10:0] span;
        logic [2:0]         sector;
        logic [5:0]         rem;
        logic               grey;
        logic [7:0]         greyv;
    } t_st4;

    typedef struct packed {
        t_tail              tl;
        logic signed [10:0] maxc;
        logic signed [10:0] minc;
        logic signed [10:0] span;
        logic signed [16:0] prod;
        logic [2:0]         sector;
        logic               grey;
        logic [7:0]         greyv;
    } t_st5;

    function automatic logic signed [10:0] f_sdiv255(input logic signed [18:0] x);
        logic [18:0] m;
        logic [9:0]  q;
        m = x[18] ? 19'(-x) : 19'(x);
        q = f_udiv255(m[16:0]);
        return x[18] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    function automatic logic [7:0] f_clamp8(input logic signed [11:0] v);
        if (v < 12'sd0) return 8'd0;
        if (v > 12'sd255) return 8'd255;
        return v[7:0];
    endfunction

    logic                  adv;
    logic [DIV_Q_W-1:0]    hq, sq;
    logic                  r_dv [DIV_Q_W];
    t_side                 r_side [DIV_Q_W];
    t_side                 side_in, sd;
    logic                  r1_valid, r2_valid, r3_valid, r4_valid, r5_valid, r_out_valid;
    t_st1                  r1, n1;
    t_st2                  r2, n2;
    t_st3                  r3, n3;
    t_st4                  r4, n4;
    t_st5                  r5, n5;
    logic [23:0]           r_rgb, n_rgb;
    logic [7:0]            r_hue, r_lum, r_sat, n_hue, n_lum, n_sat;

    // Stage-local helpers.
    logic [8:0]            hwrap;
    logic [7:0]            hval;
    logic [9:0]            lq;
    logic [10:0]           step_mag;
    logic [8:0]            dq;
    logic signed [11:0]    delta, nl_raw;
    logic [7:0]            nl, hh;
    logic [12:0]           l17, s17;
    logic signed [18:0]    ls, ss;
    logic signed [10:0]    t_hi, l11;
    logic signed [16:0]    rem17, span17;
    logic [16:0]           pmag;
    logic [10:0]           fq;
    logic signed [11:0]    frac, mx12, mn12, sp12, cr, cg, cb;

    assign adv    = !r_out_valid || o_out.ready;
    assign o_take = adv;

    assign side_in = '{op: i_work.op, grey: i_work.grey, sum: i_work.sum,
                       hue_base: i_work.hue_base, hue_neg: i_work.hue_neg,
                       in_hue: i_work.in_hue, in_lum: i_work.in_lum, in_sat: i_work.in_sat,
                       step: i_work.step, rel: i_work.rel};

    rhc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_hue_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (i_work.hue_num),
        .i_den (i_work.hue_den),
        .o_quo (hq)
    );

    rhc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_sat_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (i_work.sat_num),
        .i_den (i_work.sat_den),
        .o_quo (sq)
    );

    assign sd = r_side[DIV_Q_W-1];

    // Stage 1: assemble HLS, apply the luma step, pick the HLS to RGB operands.
    always_comb begin
        hwrap = {1'b0, sd.hue_base} + {1'b0, HUE_FULL} - 9'(hq);
        if (sd.hue_neg) begin
            hval = (8'(hq) > sd.hue_base) ? hwrap[7:0] : (sd.hue_base - 8'(hq));
        end else begin
            hval = sd.hue_base + 8'(hq);
        end
        lq       = f_udiv255(17'(sd.sum) * 17'd120);
        step_mag = sd.step[10] ? 11'(-sd.step) : 11'(sd.step);
        dq       = f_udiv25(13'(step_mag) * 13'd6);
        delta    = sd.step[10] ? -$signed({3'b0, dq}) : $signed({3'b0, dq});
        nl_raw   = sd.rel ? ($signed({4'b0, lq[7:0]}) + delta) : delta;
        if (nl_raw < 12'sd0) begin
            nl = 8'd0;
        end else if (nl_raw > $signed({4'b0, LUM_MAX})) begin
            nl = LUM_MAX;
        end else begin
            nl = nl_raw[7:0];
        end

        n1.tl.op = sd.op;
        n1.tl.h  = sd.grey ? 8'd0 : hval;
        n1.tl.l  = lq[7:0];
        n1.tl.s  = sd.grey ? 8'd0 : 8'(sq);
        if (sd.op == OP_TO_RGB) begin
            n1.th   = sd.in_hue;
            n1.tlum = sd.in_lum;
            n1.ts   = sd.in_sat;
        end else begin
            n1.th   = n1.tl.h;
            n1.tlum = nl;
            n1.ts   = n1.tl.s;
        end
    end

    // Stage 2: rescale to 0..255, split the hue into sector and remainder.
    always_comb begin
        l17 = {5'd0, r1.tlum} + {1'b0, r1.tlum, 4'd0};
        s17 = {5'd0, r1.ts} + {1'b0, r1.ts, 4'd0};
        hh  = (r1.th >= HUE_FULL) ? (r1.th - HUE_FULL) : r1.th;
        n2.tl    = r1.tl;
        n2.l255  = l17[12:4];
        n2.s255  = s17[12:4];
        n2.grey  = (r1.ts == 8'd0);
        n2.greyv = (l17[12:4] > 9'd255) ? 8'd255 : l17[11:4];
        if (hh < 8'd40) begin
            n2.sector = SEC_0;
            n2.rem    = 6'(hh);
        end else if (hh < 8'd80) begin
            n2.sector = SEC_1;
            n2.rem    = 6'(hh - 8'd40);
        end else if (hh < 8'd120) begin
            n2.sector = SEC_2;
            n2.rem    = 6'(hh - 8'd80);
        end else if (hh < 8'd160) begin
            n2.sector = SEC_3;
            n2.rem    = 6'(hh - 8'd120);
        end else if (hh < 8'd200) begin
            n2.sector = SEC_4;
            n2.rem    = 6'(hh - 8'd160);
        end else begin
            n2.sector = SEC_5;
            n2.rem    = 6'(hh - 8'd200);
        end
    end

    // Stage 3: products for the max and min channel levels.
    always_comb begin
        ls = $signed({10'd0, r2.l255});
        ss = $signed({10'd0, r2.s255});
        n3.tl     = r2.tl;
        n3.l255   = r2.l255;
        n3.lowb   = (r2.l255 <= 9'd127);
        n3.sector = r2.sector;
        n3.rem    = r2.rem;
        n3.grey   = r2.grey;
        n3.greyv  = r2.greyv;
        if (r2.l255 <= 9'd127) begin
            n3.pa = ls * (19'sd255 + ss);
            n3.pb = ls * (19'sd255 - ss);
        end else begin
            n3.pa = (19'sd255 - ls) * ss;
            n3.pb = '0;
        end
    end

    // Stage 4: divide by 255, form max, min and span.
    always_comb begin
        t_hi = f_sdiv255(r3.pa);
        l11  = $signed({2'b0, r3.l255});
        n4.tl     = r3.tl;
        n4.sector = r3.sector;
        n4.rem    = r3.rem;
        n4.grey   = r3.grey;
        n4.greyv  = r3.greyv;
        if (r3.lowb) begin
            n4.maxc = t_hi;
            n4.minc = f_sdiv255(r3.pb);
        end else begin
            n4.maxc = l11 + t_hi;
            n4.minc = l11 - t_hi;
        end
        n4.span = n4.maxc - n4.minc;
    end

    // Stage 5: remainder times span.
    always_comb begin
        rem17  = $signed({11'd0, r4.rem});
        span17 = 17'(r4.span);
        n5.tl     = r4.tl;
        n5.maxc   = r4.maxc;
        n5.minc   = r4.minc;
        n5.span   = r4.span;
        n5.prod   = rem17 * span17;
        n5.sector = r4.sector;
        n5.grey   = r4.grey;
        n5.greyv  = r4.greyv;
    end

    // Stage 6: divide by 40, place channels by sector, clamp and format the result.
    always_comb begin
        pmag = r5.prod[16] ? 17'(-r5.prod) : 17'(r5.prod);
        fq   = f_udiv40(pmag[15:0]);
        frac = r5.prod[16] ? -$signed({1'b0, fq}) : $signed({1'b0, fq});
        mx12 = 12'(r5.maxc);
        mn12 = 12'(r5.minc);
        sp12 = 12'(r5.span);
        case (r5.sector)
            SEC_0: begin
                cr = mx12;               cg = mn12 + frac;        cb = mn12;
            end
            SEC_1: begin
                cr = mn12 + sp12 - frac; cg = mx12;               cb = mn12;
            end
            SEC_2: begin
                cr = mn12;               cg = mx12;               cb = mn12 + frac;
            end
            SEC_3: begin
                cr = mn12;               cg = mn12 + sp12 - frac; cb = mx12;
            end
            SEC_4: begin
                cr = mn12 + frac;        cg = mn12;               cb = mx12;
            end
            default: begin
                cr = mx12;               cg = mn12;               cb = mn12 + sp12 - frac;
            end
        endcase

        n_rgb = '0;
        n_hue = '0;
        n_lum = '0;
        n_sat = '0;
        case (r5.tl.op) inside
            OP_TO_HLS: begin
                n_hue = r5.tl.h;
                n_lum = r5.tl.l;
                n_sat = r5.tl.s;
            end
            OP_TO_RGB, OP_LUMA: begin
                n_rgb = r5.grey ? {r5.greyv, r5.greyv, r5.greyv}
                                : {f_clamp8(cb), f_clamp8(cg), f_clamp8(cr)};
            end
            default: begin
                n_rgb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_Q_W; k++) begin
                r_dv[k] <= 1'b0;
            end
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= i_valid;
            for (int k = 1; k < DIV_Q_W; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r1_valid    <= r_dv[DIV_Q_W-1];
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= side_in;
            for (int k = 1; k < DIV_Q_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r1    <= n1;
            r2    <= n2;
            r3    <= n3;
            r4    <= n4;
            r5    <= n5;
            r_rgb <= n_rgb;
            r_hue <= n_hue;
            r_lum <= n_lum;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.out_rgb = r_rgb;
    assign o_out.out_hue = r_hue;
    assign o_out.out_lum = r_lum;
    assign o_out.out_sat = r_sat;

endmodule

/* rtl/core/rgb_hls_color_convert_core.sv */
// Top level of the RGB/HLS colour converter (0..240 HLS scale).
// Depends on rhc_pkg, rhc_if, rhc_front, rhc_queue, rhc_div and rhc_back.
//
//   port    | dir | role
//   --------+-----+---------------------------------------------------------------
//   i_in    | in  | items: op, in_rgb, in_hue, in_lum, in_sat, luma_step, relative
//   o_out   | out | results: out_rgb, out_hue, out_lum, out_sat
//
// One item per clock sustained while nothing stalls; an accepted item passes through
// the front register, 1 queue slot, 8 divider stages (one quotient bit per stage, hue
// and saturation dividers side by side) and 6 back stages before its result is presented.
// Reset is synchronous and active low; it clears valid bits, queue pointers and queue count only.
// The back advances as one pipeline whenever the output register is empty or taken;
// while it is held, the queue absorbs up to QUEUE_DEPTH items and then the front.
module rgb_hls_color_convert_core import rhc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhc_in_if.sink    i_in,
    rhc_out_if.source o_out
);
    logic      push;
    logic      pop;
    logic      take;
    t_work     front_work;
    t_work     queue_work;
    t_q_status q_status;

    // Classify: max/min, hue sector and divider operands.
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_work  (front_work)
    );

    // Decouple front from back so either side can stall on its own.
    rhc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_work   (front_work),
        .i_pop    (pop),
        .o_work   (queue_work),
        .o_status (q_status)
    );

    // Drop an item into the back only when the whole back pipeline advances.
    assign pop = take && !q_status.empty;

    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop),
        .i_work  (queue_work),
        .o_take  (take),
        .o_out   (o_out)
    );

    // The front must never write into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    // An HLS result never carries a colour.
    a_hls_no_rgb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.out_hue != 8'd0 || o_out.out_lum != 8'd0
                         || o_out.out_sat != 8'd0)) |-> (o_out.out_rgb == 24'd0))
        else $error("hls result with non-zero rgb");

    // HLS results stay on scale.
    a_hls_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.out_hue < HUE_FULL && o_out.out_lum <= LUM_MAX
                         && o_out.out_sat <= LUM_MAX))
        else $error("hls result out of range");

endmodule
